// ===== hw/rtl/mtf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

   localparam int DEPTH = 64;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_BUILD,
      STATE_SEND
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic signed [31:0] min_value;
      logic        [6:0]  count;
      logic               is_empty;
      logic               error;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic push;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/min_tracking_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// First-in first-out queue of signed 32-bit values that also reports the
// minimum of what it holds. Each request pushes, pops, clears or only queries;
// the response gives front, back, minimum, count and empty/error flags after
// the operation. The queue is a row of cells: cell 0 holds the oldest value,
// a pop shifts every cell one place toward the front, and each cell keeps the
// minimum of itself and every newer value, so cell 0 carries the queue minimum.
// A request goes through the states IDLE, which updates the cell row, BUILD,
// which forms the response register, and SEND, which hands it over; a stalled
// response holds the block in SEND until taken, and no request is accepted then.
module min_tracking_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire mtf_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output mtf_pkg::rsp_type     rsp_payload
);

   mtf_pkg::state_type          state_ff;
   mtf_pkg::state_type          state_in;
   logic [mtf_pkg::CNT_W-1:0]   count_ff;
   logic [mtf_pkg::CNT_W-1:0]   count_in;
   logic signed [31:0]          last_ff;
   logic signed [31:0]          last_in;
   logic                        error_ff;
   logic                        error_in;
   mtf_pkg::rsp_type            rsp_ff;
   mtf_pkg::rsp_type            rsp_in;
   logic                        do_push;
   logic                        do_pop;

   logic signed [31:0]          cell_value [mtf_pkg::DEPTH];
   logic signed [31:0]          cell_min   [mtf_pkg::DEPTH];
   mtf_pkg::cell_ctrl_type      cell_ctrl  [mtf_pkg::DEPTH];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      last_in   = last_ff;
      error_in  = error_ff;
      rsp_in    = rsp_ff;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         mtf_pkg::STATE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               error_in = 1'b0;
               case (req_payload.kind)
                  mtf_pkg::KIND_PUSH: begin
                     if (count_ff == mtf_pkg::CNT_W'(mtf_pkg::DEPTH)) begin
                        error_in = 1'b1;
                     end else begin
                        do_push  = 1'b1;
                        count_in = count_ff + mtf_pkg::CNT_W'(1);
                        last_in  = req_payload.value;
                     end
                  end
                  mtf_pkg::KIND_POP: begin
                     if (count_ff == '0) begin
                        error_in = 1'b1;
                     end else begin
                        do_pop   = 1'b1;
                        count_in = count_ff - mtf_pkg::CNT_W'(1);
                     end
                  end
                  mtf_pkg::KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               state_in = mtf_pkg::STATE_BUILD;
            end
         end
         mtf_pkg::STATE_BUILD: begin
            rsp_in.count    = 7'(count_ff);
            rsp_in.error    = error_ff;
            rsp_in.is_empty = (count_ff == '0);
            if (count_ff == '0) begin
               rsp_in.front_value = '0;
               rsp_in.back_value  = '0;
               rsp_in.min_value   = '0;
            end else begin
               rsp_in.front_value = cell_value[0];
               rsp_in.back_value  = last_ff;
               rsp_in.min_value   = cell_min[0];
            end
            state_in = mtf_pkg::STATE_SEND;
         end
         mtf_pkg::STATE_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = mtf_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = mtf_pkg::STATE_IDLE;
         end
      endcase
   end

   genvar i;
   generate
      for (i = 0; i < mtf_pkg::DEPTH; i++) begin : g_cell
         logic signed [31:0] next_value;
         logic signed [31:0] next_min;

         assign cell_ctrl[i].shift = do_pop;
         assign cell_ctrl[i].load  = do_push && (count_ff == mtf_pkg::CNT_W'(i));
         assign cell_ctrl[i].push  = do_push;

         if (i < mtf_pkg::DEPTH - 1) begin : g_link
            assign next_value = cell_value[i+1];
            assign next_min   = cell_min[i+1];
         end else begin : g_tail
            assign next_value = '0;
            assign next_min   = '0;
         end

         mtf_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[i]),
            .push_value (req_payload.value),
            .next_value (next_value),
            .next_min   (next_min),
            .cell_value (cell_value[i]),
            .cell_min   (cell_min[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtf_pkg::STATE_IDLE;
         count_ff <= '0;
         last_ff  <= '0;
         error_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
         error_ff <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mtf_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtf_cell (
   input  wire                        clock,
   input  wire mtf_pkg::cell_ctrl_type ctrl,
   input  wire logic signed [31:0]    push_value,
   input  wire logic signed [31:0]    next_value,
   input  wire logic signed [31:0]    next_min,
   output logic signed [31:0]         cell_value,
   output logic signed [31:0]         cell_min
);

   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic signed [31:0] min_ff;
   logic signed [31:0] min_in;

   always_comb begin
      value_in = value_ff;
      min_in   = min_ff;
      if (ctrl.shift) begin
         value_in = next_value;
         min_in   = next_min;
      end else if (ctrl.load) begin
         value_in = push_value;
         min_in   = push_value;
      end else if (ctrl.push) begin
         min_in = (push_value < min_ff) ? push_value : min_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      min_ff   <= min_in;
   end

   assign cell_value = value_ff;
   assign cell_min   = min_ff;

endmodule

`default_nettype wire

// ===== tb/sv/min_tracking_fifo_test.sv =====
`timescale 1ns / 1ps

module min_tracking_fifo_test;

   localparam int NUM_STEPS = 23;
   localparam int STALL_LIMIT = 5000;
   localparam int SEGMENT_REQUESTS = 50;
   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

   typedef struct {
      mtf_pkg::req_type request;
      bit               literal;
      mtf_pkg::rsp_type status;
   } step_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mtf_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mtf_pkg::rsp_type rsp_payload;

   logic signed [31:0] held_values[$];
   logic signed [31:0] newest_value = '0;
   mtf_pkg::rsp_type   pending_status[$];
   mtf_pkg::rsp_type   predicted;
   step_row_type       steps[NUM_STEPS];
   int                 accepted = 0;
   int                 failures = 0;
   int                 idle_cycles = 0;
   int                 send_idle_pct = 0;
   int                 recv_stall_pct = 0;

   min_tracking_fifo dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   function automatic mtf_pkg::rsp_type next_queue_status(mtf_pkg::req_type r);
      mtf_pkg::rsp_type   s;
      logic signed [31:0] least;
      bit                 fault;
      fault = 1'b0;
      case (r.kind)
         mtf_pkg::KIND_PUSH: begin
            if (held_values.size() >= mtf_pkg::DEPTH) begin
               fault = 1'b1;
            end else begin
               held_values.push_back(r.value);
               newest_value = r.value;
            end
         end
         mtf_pkg::KIND_POP: begin
            if (held_values.size() == 0) begin
               fault = 1'b1;
            end else begin
               void'(held_values.pop_front());
            end
         end
         mtf_pkg::KIND_CLEAR: begin
            held_values.delete();
         end
         default: begin
         end
      endcase
      s = '0;
      if (held_values.size() != 0) begin
         least = held_values[0];
         foreach (held_values[i]) begin
            if (held_values[i] < least) begin
               least = held_values[i];
            end
         end
         s.front_value = held_values[0];
         s.back_value = newest_value;
         s.min_value = least;
      end
      s.count = 7'(held_values.size());
      s.is_empty = (held_values.size() == 0);
      s.error = fault;
      return s;
   endfunction

   function automatic step_row_type via_model(mtf_pkg::kind_type k, logic signed [31:0] v);
      step_row_type row;
      row.request.kind = k;
      row.request.value = v;
      row.literal = 1'b0;
      row.status = '0;
      return row;
   endfunction

   function automatic step_row_type with_status(mtf_pkg::kind_type k, logic signed [31:0] v,
                                                logic signed [31:0] front,
                                                logic signed [31:0] back,
                                                logic signed [31:0] least,
                                                int n, bit empty, bit fault);
      step_row_type row;
      row = via_model(k, v);
      row.literal = 1'b1;
      row.status.front_value = front;
      row.status.back_value = back;
      row.status.min_value = least;
      row.status.count = 7'(n);
      row.status.is_empty = empty;
      row.status.error = fault;
      return row;
   endfunction

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 9))
         0: return MOST_NEGATIVE;
         1: return MOST_POSITIVE;
         2, 3, 4: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
         default: return $urandom;
      endcase
   endfunction

   function automatic mtf_pkg::kind_type random_kind(int push_pct, int pop_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < push_pct) return mtf_pkg::KIND_PUSH;
      if (pick < push_pct + pop_pct) return mtf_pkg::KIND_POP;
      if (pick < push_pct + pop_pct + 2) return mtf_pkg::KIND_CLEAR;
      return mtf_pkg::KIND_QUERY;
   endfunction

   task automatic report_field(string field, longint want, longint got);
      failures++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   task automatic check_status(mtf_pkg::rsp_type want, mtf_pkg::rsp_type got);
      if (want.front_value !== got.front_value)
         report_field("front_value", want.front_value, got.front_value);
      if (want.back_value !== got.back_value)
         report_field("back_value", want.back_value, got.back_value);
      if (want.min_value !== got.min_value)
         report_field("min_value", want.min_value, got.min_value);
      if (want.count !== got.count)
         report_field("count", want.count, got.count);
      if (want.is_empty !== got.is_empty)
         report_field("is_empty", want.is_empty, got.is_empty);
      if (want.error !== got.error)
         report_field("error", want.error, got.error);
   endtask

   task automatic send_request(mtf_pkg::kind_type k, logic signed [31:0] v);
      mtf_pkg::req_type r;
      r.kind = k;
      r.value = v;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_payload <= {mtf_pkg::kind_type'($urandom_range(0, 3)), 32'($urandom)};
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_status.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            predicted = next_queue_status(req_payload);
            if (accepted < NUM_STEPS && steps[accepted].literal) begin
               predicted = steps[accepted].status;
            end
            pending_status.push_back(predicted);
            accepted++;
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (pending_status.size() == 0) begin
               failures++;
               $display("%0t: response with no request outstanding, expected none, got %p",
                        $time, rsp_payload);
            end else begin
               check_status(pending_status.pop_front(), rsp_payload);
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("min_tracking_fifo_test: FAIL");
            $finish;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   initial begin
      int send_pcts[4];
      int recv_pcts[4];
      int push_pcts[3];
      int pop_pcts[3];
      send_pcts = '{0, 73, 0, 8};
      recv_pcts = '{0, 0, 73, 8};
      push_pcts = '{78, 25, 45};
      pop_pcts = '{15, 65, 40};

      steps[0] = with_status(mtf_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 1, 0);
      steps[1] = with_status(mtf_pkg::KIND_POP, 0, 0, 0, 0, 0, 1, 1);
      steps[2] = with_status(mtf_pkg::KIND_CLEAR, 123, 0, 0, 0, 0, 1, 0);
      steps[3] = with_status(mtf_pkg::KIND_PUSH, MOST_NEGATIVE, MOST_NEGATIVE, MOST_NEGATIVE,
                             MOST_NEGATIVE, 1, 0, 0);
      steps[4] = with_status(mtf_pkg::KIND_PUSH, MOST_POSITIVE, MOST_NEGATIVE, MOST_POSITIVE,
                             MOST_NEGATIVE, 2, 0, 0);
      steps[5] = with_status(mtf_pkg::KIND_QUERY, -1, MOST_NEGATIVE, MOST_POSITIVE,
                             MOST_NEGATIVE, 2, 0, 0);
      steps[6] = with_status(mtf_pkg::KIND_POP, 0, MOST_POSITIVE, MOST_POSITIVE,
                             MOST_POSITIVE, 1, 0, 0);
      steps[7] = via_model(mtf_pkg::KIND_PUSH, -1);
      steps[8] = via_model(mtf_pkg::KIND_PUSH, 0);
      steps[9] = via_model(mtf_pkg::KIND_PUSH, -1);
      steps[10] = via_model(mtf_pkg::KIND_PUSH, 3);
      steps[11] = via_model(mtf_pkg::KIND_POP, 0);
      steps[12] = via_model(mtf_pkg::KIND_POP, 7);
      steps[13] = via_model(mtf_pkg::KIND_QUERY, MOST_POSITIVE);
      steps[14] = with_status(mtf_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 1, 0);
      steps[15] = with_status(mtf_pkg::KIND_QUERY, MOST_NEGATIVE, 0, 0, 0, 0, 1, 0);
      steps[16] = via_model(mtf_pkg::KIND_PUSH, 5);
      steps[17] = with_status(mtf_pkg::KIND_POP, 0, 0, 0, 0, 0, 1, 0);
      steps[18] = with_status(mtf_pkg::KIND_POP, 0, 0, 0, 0, 0, 1, 1);
      steps[19] = via_model(mtf_pkg::KIND_PUSH, MOST_POSITIVE);
      steps[20] = via_model(mtf_pkg::KIND_PUSH, MOST_NEGATIVE);
      steps[21] = via_model(mtf_pkg::KIND_POP, 0);
      steps[22] = via_model(mtf_pkg::KIND_CLEAR, -1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         send_request(steps[i].request.kind, steps[i].request.value);
      end
      hold_until_drained();

      // fill past the top, then drain past the bottom
      repeat (mtf_pkg::DEPTH + 2) send_request(mtf_pkg::KIND_PUSH, random_value());
      send_request(mtf_pkg::KIND_QUERY, random_value());
      repeat (mtf_pkg::DEPTH + 1) send_request(mtf_pkg::KIND_POP, random_value());
      hold_until_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_pcts[ph];
         recv_stall_pct = recv_pcts[ph];
         for (int seg = 0; seg < 3; seg++) begin
            repeat (SEGMENT_REQUESTS) begin
               send_request(random_kind(push_pcts[seg], pop_pcts[seg]), random_value());
            end
         end
         hold_until_drained();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);
      if (failures == 0 && pending_status.size() == 0) begin
         $display("min_tracking_fifo_test: PASS");
      end else begin
         $display("min_tracking_fifo_test: FAIL");
      end
      $finish;
   end

endmodule
